// ===== design/assert_macros.svh =====
// Shared assertion macros for the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is low.
`define FFEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication check, disabled while reset is low.
`define FFEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/ffea_pkg.sv =====
package ffea_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    RSEL_NONE,
    RSEL_CUR,
    RSEL_SHIFT
  } rsel_e;

  typedef enum logic [2:0] {
    WSEL_NONE,
    WSEL_BASE_ADD,
    WSEL_BASE_START,
    WSEL_PREV_LIM_CUR,
    WSEL_PREV_LIM_END,
    WSEL_NEW,
    WSEL_SHIFT
  } wsel_e;

  typedef struct packed {
    logic       load_req;
    logic       inc_idx;
    logic       save_prev;
    rsel_e      rsel;
    wsel_e      wsel;
    logic       ptr_init_rem;
    logic       ptr_init_ins;
    logic       ptr_step;
    logic       set_grant;
    logic       set_status;
    logic [1:0] status_code;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic range_err;
    logic empty;
    logic full;
    logic fit_gt;
    logic fit_eq;
    logic base_eq_end;
    logic base_gt_end;
    logic left;
    logic last;
    logic tail_merge;
    logic ins_at_ptr;
    logic rem_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== design/ffea_dp.sv =====
module ffea_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffea_pkg::dp_cmd_t cmd_i,
  output ffea_pkg::dp_sts_t sts_o,
  input  logic              kind_i,
  input  logic [15:0]       start_req_i,
  input  logic [15:0]       length_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [15:0]       granted_start_o,
  output logic [1:0]        status_o
);
  import ffea_pkg::*;

  localparam int W    = ADDR_BITS + 1;
  localparam int XW   = (W > 17) ? W : 17;
  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [XW-1:0] SPACE = XW'(1) << ADDR_BITS;

  logic [2*W-1:0] mem [TABLE_DEPTH];
  logic [2*W-1:0] rdata_q;

  logic            kind_q;
  logic [XW-1:0]   start_q, len_q;
  logic [CNTW-1:0] count_q, idx_q, ptr_q;
  logic            ins_mode_q;
  logic [W-1:0]    prev_base_q, prev_lim_q;
  logic [15:0]     grant_q;
  logic [1:0]      stat_q;
  logic            out_valid_q;
  logic [15:0]     out_grant_q;
  logic [1:0]      out_stat_q;

  logic [XW-1:0]   end_x, rbase_x, rlim_x, size_x, start_w_x;
  logic [W-1:0]    rbase, rlim, start_w, end_w;
  logic [CNTW-1:0] idx_m1, ptr_p1, ptr_m1, idx_p1;
  logic            rd_en, wr_en;
  logic [IW-1:0]   raddr, waddr;
  logic [2*W-1:0]  wdata;

  assign end_x     = start_q + len_q;
  assign rbase     = rdata_q[2*W-1:W];
  assign rlim      = rdata_q[W-1:0];
  assign rbase_x   = XW'(rbase);
  assign rlim_x    = XW'(rlim);
  assign size_x    = rlim_x - rbase_x;
  assign start_w   = W'(start_q);
  assign end_w     = W'(end_x);
  assign start_w_x = XW'(prev_lim_q);
  assign idx_m1    = idx_q - CNTW'(1);
  assign idx_p1    = idx_q + CNTW'(1);
  assign ptr_p1    = ptr_q + CNTW'(1);
  assign ptr_m1    = ptr_q - CNTW'(1);

  always_comb begin
    rd_en = 1'b1;
    raddr = idx_q[IW-1:0];
    case (cmd_i.rsel)
      RSEL_CUR:   raddr = idx_q[IW-1:0];
      RSEL_SHIFT: raddr = ins_mode_q ? ptr_m1[IW-1:0] : ptr_p1[IW-1:0];
      default:    rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    waddr = idx_q[IW-1:0];
    wdata = rdata_q;
    case (cmd_i.wsel)
      WSEL_BASE_ADD:     wdata = {W'(rbase_x + len_q), rlim};
      WSEL_BASE_START:   wdata = {start_w, rlim};
      WSEL_PREV_LIM_CUR: begin
        waddr = idx_m1[IW-1:0];
        wdata = {prev_base_q, rlim};
      end
      WSEL_PREV_LIM_END: begin
        waddr = idx_m1[IW-1:0];
        wdata = {prev_base_q, end_w};
      end
      WSEL_NEW:          wdata = {start_w, end_w};
      WSEL_SHIFT:        waddr = ptr_q[IW-1:0];
      default:           wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Request and scan payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q  <= kind_i;
      start_q <= XW'(start_req_i);
      len_q   <= XW'(length_i);
      grant_q <= '0;
      stat_q  <= ST_OK;
    end else begin
      if (cmd_i.set_grant) begin
        grant_q <= rbase_x[15:0];
      end
      if (cmd_i.set_status) begin
        stat_q <= cmd_i.status_code;
      end
    end
    if (cmd_i.save_prev) begin
      prev_base_q <= rbase;
      prev_lim_q  <= rlim;
    end
    if (cmd_i.res_load) begin
      out_grant_q <= grant_q;
      out_stat_q  <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      ptr_q       <= '0;
      ins_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_p1;
      end
      if (cmd_i.ptr_init_rem) begin
        ptr_q      <= idx_q;
        ins_mode_q <= 1'b0;
      end else if (cmd_i.ptr_init_ins) begin
        ptr_q      <= count_q;
        ins_mode_q <= 1'b1;
      end else if (cmd_i.ptr_step) begin
        ptr_q <= ins_mode_q ? ptr_m1 : ptr_p1;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNTW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNTW'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_release  = (kind_q == KIND_RELEASE);
  assign sts_o.range_err   = (end_x > SPACE);
  assign sts_o.empty       = (count_q == '0);
  assign sts_o.full        = (count_q == CNTW'(TABLE_DEPTH));
  assign sts_o.fit_gt      = (size_x > len_q);
  assign sts_o.fit_eq      = (size_x == len_q);
  assign sts_o.base_eq_end = (rbase_x == end_x);
  assign sts_o.base_gt_end = (rbase_x > end_x);
  assign sts_o.left        = (idx_q != '0) && (start_w_x == start_q);
  assign sts_o.last        = (idx_p1 == count_q);
  assign sts_o.tail_merge  = (start_w_x == start_q);
  assign sts_o.ins_at_ptr  = (ptr_q == idx_q);
  assign sts_o.rem_done    = (ptr_p1 >= count_q);
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign granted_start_o = out_grant_q;
  assign status_o        = out_stat_q;

endmodule

// ===== design/ffea_ctrl.sv =====
module ffea_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ffea_pkg::dp_sts_t sts_i,
  output ffea_pkg::dp_cmd_t cmd_o
);
  import ffea_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_TAIL = 4'd4;
  localparam logic [3:0] S_INS  = 4'd5;
  localparam logic [3:0] S_ISH  = 4'd6;
  localparam logic [3:0] S_ISW  = 4'd7;
  localparam logic [3:0] S_RSH  = 4'd8;
  localparam logic [3:0] S_RSW  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rsel = RSEL_NONE;
    cmd_o.wsel = WSEL_NONE;
    in_ready_o = 1'b0;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.is_release && sts_i.range_err) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_RANGE;
          state_d           = S_DONE;
        end else if (sts_i.empty) begin
          if (sts_i.is_release) begin
            state_d = S_INS;
          end else begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_NOFIT;
            state_d           = S_DONE;
          end
        end else begin
          cmd_o.rsel = RSEL_CUR;
          state_d    = S_EV;
        end
      end
      S_RD: begin
        cmd_o.rsel = RSEL_CUR;
        state_d    = S_EV;
      end
      S_EV: begin
        if (!sts_i.is_release && sts_i.fit_gt) begin
          cmd_o.wsel      = WSEL_BASE_ADD;
          cmd_o.set_grant = 1'b1;
          state_d         = S_DONE;
        end else if (!sts_i.is_release && sts_i.fit_eq) begin
          cmd_o.set_grant    = 1'b1;
          cmd_o.ptr_init_rem = 1'b1;
          state_d            = S_RSH;
        end else if (sts_i.is_release && sts_i.base_eq_end) begin
          if (sts_i.left) begin
            // Bridge the gap: widen the left extent, drop this one.
            cmd_o.wsel         = WSEL_PREV_LIM_CUR;
            cmd_o.ptr_init_rem = 1'b1;
            state_d            = S_RSH;
          end else begin
            cmd_o.wsel = WSEL_BASE_START;
            state_d    = S_DONE;
          end
        end else if (sts_i.is_release && sts_i.base_gt_end) begin
          if (sts_i.left) begin
            cmd_o.wsel = WSEL_PREV_LIM_END;
            state_d    = S_DONE;
          end else begin
            state_d = S_INS;
          end
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.inc_idx   = 1'b1;
          if (!sts_i.last) begin
            state_d = S_RD;
          end else if (sts_i.is_release) begin
            state_d = S_TAIL;
          end else begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_NOFIT;
            state_d           = S_DONE;
          end
        end
      end
      S_TAIL: begin
        if (sts_i.tail_merge) begin
          cmd_o.wsel = WSEL_PREV_LIM_END;
          state_d    = S_DONE;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (sts_i.full) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_FULL;
          state_d           = S_DONE;
        end else begin
          cmd_o.ptr_init_ins = 1'b1;
          state_d            = S_ISH;
        end
      end
      S_ISH: begin
        if (sts_i.ins_at_ptr) begin
          cmd_o.wsel    = WSEL_NEW;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rsel = RSEL_SHIFT;
          state_d    = S_ISW;
        end
      end
      S_ISW: begin
        cmd_o.wsel     = WSEL_SHIFT;
        cmd_o.ptr_step = 1'b1;
        state_d        = S_ISH;
      end
      S_RSH: begin
        if (sts_i.rem_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rsel = RSEL_SHIFT;
          state_d    = S_RSW;
        end
      end
      S_RSW: begin
        cmd_o.wsel     = WSEL_SHIFT;
        cmd_o.ptr_step = 1'b1;
        state_d        = S_RSH;
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/first_fit_extent_allocator_top.sv =====
// Channel | Direction | Handshake               | Payload
// request | in        | in_valid_i / in_ready_o | kind_i, start_req_i, length_i
// result  | out       | out_valid_o / out_ready_i | granted_start_o, status_o
//
// One request at a time: accept and check, scan the extents in table order,
// move extents on insert or remove, then finish. Scan and move share the
// table, whose reads are registered.
// Reset leaves the table empty (count zero); no clearing pass is needed.
// A new request is taken while a finished result waits in the output register.
module first_fit_extent_allocator_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] start_req_i,
  input  logic [15:0] length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] granted_start_o,
  output logic [1:0]  status_o
);
  import ffea_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ffea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffea_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .start_req_i     (start_req_i),
    .length_i        (length_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .granted_start_o (granted_start_o),
    .status_o        (status_o)
  );

`include "assert_macros.svh"

  `FFEA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `FFEA_ASSERT_IMP(a_fail_no_grant, out_valid_o && status_o != ST_OK,
                   granted_start_o == 16'd0, "grant on failure")
  `FFEA_ASSERT_IMP(a_count_bound, !sts.empty, !(sts.full && sts.empty), "count flags clash")

endmodule
